### src/button_debounce_longpress_fsm_core_macros.svh
// Assertion macros for the pushbutton debouncer core.
`ifndef BUTTON_DEBOUNCE_LONGPRESS_FSM_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_FSM_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define BDLP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdlp: same-cycle check failed");

// next-cycle implication, disabled in reset
`define BDLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdlp: next-cycle check failed");

`endif

### src/bdlp_pkg.sv
// Shared types, codes and reset values for the pushbutton debouncer.
package bdlp_pkg;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned IDX_W  = 3;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_ACTIVE_LEVEL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESS_DEB     = 3'd1;
  localparam logic [IDX_W-1:0] REG_RELEASE_DEB   = 3'd2;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS    = 3'd3;
  localparam logic [IDX_W-1:0] REG_REPEAT        = 3'd4;
  localparam logic [IDX_W-1:0] REG_BUTTON_MODE   = 3'd5;

  // button modes; code 3 is unused
  localparam logic [1:0] MODE_MOMENTARY = 2'd0;
  localparam logic [1:0] MODE_LATCH     = 2'd1;
  localparam logic [1:0] MODE_TOGGLE    = 2'd2;

  localparam logic              RST_ACTIVE_LEVEL = 1'b1;
  localparam logic [TICK_W-1:0] RST_PRESS_DEB    = 32'd10;
  localparam logic [TICK_W-1:0] RST_RELEASE_DEB  = 32'd10;
  localparam logic [TICK_W-1:0] RST_LONG_PRESS   = 32'd0;
  localparam logic [TICK_W-1:0] RST_REPEAT       = 32'd0;
  localparam logic [1:0]        RST_BUTTON_MODE  = MODE_MOMENTARY;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SHORT     = 3'd1,
    EV_LONG      = 3'd2,
    EV_SHORT_REL = 3'd3,
    EV_LONG_REL  = 3'd4,
    EV_REPEAT    = 3'd5,
    EV_SW_ON     = 3'd6,
    EV_SW_OFF    = 3'd7
  } event_t;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_DEB_ON    = 6'b000010,
    ST_SHORT     = 6'b000100,
    ST_SHORT_OFF = 6'b001000,
    ST_LONG      = 6'b010000,
    ST_LONG_OFF  = 6'b100000
  } state_t;

  // external state numbering
  localparam logic [2:0] CODE_IDLE      = 3'd0;
  localparam logic [2:0] CODE_DEB_ON    = 3'd1;
  localparam logic [2:0] CODE_SHORT     = 3'd2;
  localparam logic [2:0] CODE_SHORT_OFF = 3'd3;
  localparam logic [2:0] CODE_LONG      = 3'd4;
  localparam logic [2:0] CODE_LONG_OFF  = 3'd5;

  typedef struct packed {
    logic              active_level;
    logic [TICK_W-1:0] press_debounce_ticks;
    logic [TICK_W-1:0] release_debounce_ticks;
    logic [TICK_W-1:0] long_press_ticks;
    logic [TICK_W-1:0] repeat_ticks;
    logic [1:0]        button_mode;
  } cfg_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [2:0] button_state;
    logic       logic_value;
  } step_res_t;

  function automatic logic [2:0] state_code(input state_t st);
    logic [2:0] code;
    case (st)
      ST_IDLE:      code = CODE_IDLE;
      ST_DEB_ON:    code = CODE_DEB_ON;
      ST_SHORT:     code = CODE_SHORT;
      ST_SHORT_OFF: code = CODE_SHORT_OFF;
      ST_LONG:      code = CODE_LONG;
      ST_LONG_OFF:  code = CODE_LONG_OFF;
      default:      code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

### src/bdlp_if.sv
// Valid/ready stream interfaces for poll beats and result beats.
interface bdlp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          raw_level;
  logic [bdlp_pkg::TICK_W-1:0]   tick_now;

  modport source (output valid, output raw_level, output tick_now, input ready);
  modport sink   (input valid, input raw_level, input tick_now, output ready);
endinterface

interface bdlp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic [2:0] button_state;
  logic       logic_value;

  modport source (output valid, output event_code, output button_state,
                  output logic_value, input ready);
  modport sink   (input valid, input event_code, input button_state,
                  input logic_value, output ready);
endinterface

### src/button_debounce_longpress_fsm_core.sv
// Result: the result beat of an accepted poll is registered and offered in the cycle after the poll is taken.
// Throughput: one poll per cycle while result.ready is high; the result register frees itself in the cycle it is taken.
// Timing: one 32-bit subtract and compare against a state-selected limit per poll.
// Reset: synchronous, active high; state idle, stamp and switch zero, registers
// back to their defaults, no result pending.
`include "button_debounce_longpress_fsm_core_macros.svh"

module button_debounce_longpress_fsm_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bdlp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::TICK_W-1:0]  cfg_data,
  bdlp_in_if.sink                      poll,
  bdlp_out_if.source                   result
);

  bdlp_pkg::cfg_t      cfg;
  bdlp_pkg::step_res_t res;
  bdlp_pkg::step_res_t res_q;
  logic                out_valid;
  logic                in_beat;

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign poll.ready = !out_valid || result.ready;
  assign in_beat    = poll.valid && poll.ready;

  bdlp_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step_en   (in_beat),
    .raw_level (poll.raw_level),
    .tick_now  (poll.tick_now),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_q <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.event_code   = res_q.event_code;
  assign result.button_state = res_q.button_state;
  assign result.logic_value  = res_q.logic_value;

  `BDLP_ASSERT_NEXT(a_beat_gives_result, clk, rst, in_beat, result.valid)
  `BDLP_ASSERT_SAME(a_stall_blocks_input, clk, rst, result.valid && !result.ready,
    !poll.ready)
  `BDLP_ASSERT_SAME(a_long_events_in_long, clk, rst,
    result.valid && (result.event_code == bdlp_pkg::EV_LONG ||
                     result.event_code == bdlp_pkg::EV_REPEAT),
    result.button_state == bdlp_pkg::CODE_LONG)
  `BDLP_ASSERT_SAME(a_momentary_value, clk, rst,
    result.valid && cfg.button_mode == bdlp_pkg::MODE_MOMENTARY,
    result.logic_value == (result.button_state != bdlp_pkg::CODE_IDLE &&
                           result.button_state != bdlp_pkg::CODE_DEB_ON))

endmodule

### src/bdlp_cfg.sv
// Configuration register file, write-only.
module bdlp_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bdlp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::TICK_W-1:0]  cfg_data,
  output bdlp_pkg::cfg_t               cfg
);

  bdlp_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.active_level           <= bdlp_pkg::RST_ACTIVE_LEVEL;
      regs.press_debounce_ticks   <= bdlp_pkg::RST_PRESS_DEB;
      regs.release_debounce_ticks <= bdlp_pkg::RST_RELEASE_DEB;
      regs.long_press_ticks       <= bdlp_pkg::RST_LONG_PRESS;
      regs.repeat_ticks           <= bdlp_pkg::RST_REPEAT;
      regs.button_mode            <= bdlp_pkg::RST_BUTTON_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        bdlp_pkg::REG_ACTIVE_LEVEL: regs.active_level           <= cfg_data[0];
        bdlp_pkg::REG_PRESS_DEB:    regs.press_debounce_ticks   <= cfg_data;
        bdlp_pkg::REG_RELEASE_DEB:  regs.release_debounce_ticks <= cfg_data;
        bdlp_pkg::REG_LONG_PRESS:   regs.long_press_ticks       <= cfg_data;
        bdlp_pkg::REG_REPEAT:       regs.repeat_ticks           <= cfg_data;
        bdlp_pkg::REG_BUTTON_MODE:  regs.button_mode            <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### src/bdlp_fsm.sv
// Debounce / long-press state machine: state registers and per-poll update.
module bdlp_fsm (
  input  logic                         clk,
  input  logic                         rst,
  input  bdlp_pkg::cfg_t               cfg,
  input  logic                         step_en,
  input  logic                         raw_level,
  input  logic [bdlp_pkg::TICK_W-1:0]  tick_now,
  output bdlp_pkg::step_res_t          res
);

  bdlp_pkg::state_t            state, state_next;
  logic                        previous_level;
  logic [bdlp_pkg::TICK_W-1:0] event_stamp, event_stamp_next;
  logic                        switch_value, switch_value_next;

  logic                        act;
  logic [bdlp_pkg::TICK_W-1:0] elapsed;
  logic [bdlp_pkg::TICK_W-1:0] limit;
  logic                        over;
  bdlp_pkg::event_t            ev;
  logic                        pressed_next;

  assign act     = (raw_level == cfg.active_level);
  assign elapsed = tick_now - event_stamp;

  // one limit per state, one compare
  always_comb begin
    case (state)
      bdlp_pkg::ST_DEB_ON:    limit = cfg.press_debounce_ticks;
      bdlp_pkg::ST_SHORT:     limit = cfg.long_press_ticks;
      bdlp_pkg::ST_LONG:      limit = cfg.repeat_ticks;
      bdlp_pkg::ST_SHORT_OFF: limit = cfg.release_debounce_ticks;
      bdlp_pkg::ST_LONG_OFF:  limit = cfg.release_debounce_ticks;
      default:                limit = cfg.press_debounce_ticks;
    endcase
  end

  assign over = (elapsed > limit);

  always_comb begin
    state_next        = state;
    event_stamp_next  = event_stamp;
    switch_value_next = switch_value;
    ev                = bdlp_pkg::EV_NONE;
    case (state)
      bdlp_pkg::ST_IDLE: begin
        if (act) begin
          event_stamp_next = tick_now;
          state_next       = bdlp_pkg::ST_DEB_ON;
        end
      end
      bdlp_pkg::ST_DEB_ON: begin
        if (act == previous_level) begin
          if (over) begin
            if (act) begin
              state_next       = bdlp_pkg::ST_SHORT;
              event_stamp_next = tick_now;
              case (cfg.button_mode)
                bdlp_pkg::MODE_MOMENTARY: ev = bdlp_pkg::EV_SHORT;
                bdlp_pkg::MODE_LATCH: begin
                  if (switch_value) begin
                    ev                = bdlp_pkg::EV_SW_OFF;
                    switch_value_next = 1'b0;
                  end else begin
                    ev = bdlp_pkg::EV_SHORT;
                  end
                end
                bdlp_pkg::MODE_TOGGLE: begin
                  ev = switch_value ? bdlp_pkg::EV_SW_OFF : bdlp_pkg::EV_SW_ON;
                  switch_value_next = ~switch_value;
                end
                default: ;
              endcase
            end else begin
              state_next = bdlp_pkg::ST_IDLE;
            end
          end
        end else if (act) begin
          event_stamp_next = tick_now;
        end
      end
      bdlp_pkg::ST_SHORT: begin
        if (!act) begin
          state_next       = bdlp_pkg::ST_SHORT_OFF;
          event_stamp_next = tick_now;
        end else if ((cfg.long_press_ticks != '0) && over) begin
          state_next       = bdlp_pkg::ST_LONG;
          event_stamp_next = tick_now;
          case (cfg.button_mode)
            bdlp_pkg::MODE_MOMENTARY: ev = bdlp_pkg::EV_LONG;
            bdlp_pkg::MODE_LATCH: begin
              switch_value_next = 1'b1;
              ev                = bdlp_pkg::EV_SW_ON;
            end
            default: ;
          endcase
        end
      end
      bdlp_pkg::ST_LONG: begin
        if (!act) begin
          state_next       = bdlp_pkg::ST_LONG_OFF;
          event_stamp_next = tick_now;
        end else if ((cfg.repeat_ticks != '0) && over) begin
          event_stamp_next = tick_now;
          ev               = bdlp_pkg::EV_REPEAT;
        end
      end
      bdlp_pkg::ST_SHORT_OFF, bdlp_pkg::ST_LONG_OFF: begin
        if (act) begin
          event_stamp_next = tick_now;
          state_next = (state == bdlp_pkg::ST_SHORT_OFF) ? bdlp_pkg::ST_SHORT
                                                         : bdlp_pkg::ST_LONG;
        end else if (act != previous_level) begin
          event_stamp_next = tick_now;
        end else if (over) begin
          ev = (state == bdlp_pkg::ST_SHORT_OFF) ? bdlp_pkg::EV_SHORT_REL
                                                 : bdlp_pkg::EV_LONG_REL;
          state_next       = bdlp_pkg::ST_IDLE;
          event_stamp_next = tick_now;
        end
      end
      default: begin
        state_next       = bdlp_pkg::ST_IDLE;
        event_stamp_next = tick_now;
      end
    endcase
  end

  assign pressed_next = (state_next != bdlp_pkg::ST_IDLE) &&
                        (state_next != bdlp_pkg::ST_DEB_ON);

  assign res.event_code   = ev;
  assign res.button_state = bdlp_pkg::state_code(state_next);
  assign res.logic_value  = (cfg.button_mode == bdlp_pkg::MODE_MOMENTARY) ?
                            pressed_next : switch_value_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bdlp_pkg::ST_IDLE;
      previous_level <= 1'b0;
      event_stamp    <= '0;
      switch_value   <= 1'b0;
    end else if (step_en) begin
      state          <= state_next;
      previous_level <= act;
      event_stamp    <= event_stamp_next;
      switch_value   <= switch_value_next;
    end
  end

endmodule

### test/button_debounce_longpress_fsm_core_tb.sv
`timescale 1ns / 100ps
// Testbench for the pushbutton debouncer core: directed and random polls checked beat by beat.
module button_debounce_longpress_fsm_core_tb;

  localparam int PHASES = 12;
  localparam int PHASE_POLLS = 112;

  typedef struct packed {
    logic                        raw_level;
    logic [bdlp_pkg::TICK_W-1:0] tick_now;
  } poll_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [bdlp_pkg::IDX_W-1:0]  cfg_index = bdlp_pkg::REG_ACTIVE_LEVEL;
  logic [bdlp_pkg::TICK_W-1:0] cfg_data = '0;

  bdlp_in_if  poll_if ();
  bdlp_out_if res_if ();

  button_debounce_longpress_fsm_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .poll      (poll_if),
    .result    (res_if)
  );

  // predictor copy of the registers and the button state
  logic                        cur_active = bdlp_pkg::RST_ACTIVE_LEVEL;
  logic [bdlp_pkg::TICK_W-1:0] cur_press_deb = bdlp_pkg::RST_PRESS_DEB;
  logic [bdlp_pkg::TICK_W-1:0] cur_release_deb = bdlp_pkg::RST_RELEASE_DEB;
  logic [bdlp_pkg::TICK_W-1:0] cur_long = bdlp_pkg::RST_LONG_PRESS;
  logic [bdlp_pkg::TICK_W-1:0] cur_repeat = bdlp_pkg::RST_REPEAT;
  logic [1:0]                  cur_mode = bdlp_pkg::RST_BUTTON_MODE;
  logic [2:0]                  btn_state = bdlp_pkg::CODE_IDLE;
  logic                        prev_act = 1'b0;
  logic [bdlp_pkg::TICK_W-1:0] stamp = '0;
  logic                        sw_on = 1'b0;

  poll_t                 poll_queue[$];
  bdlp_pkg::step_res_t   expected_reports[$];
  poll_t                 outgoing_poll;
  bdlp_pkg::step_res_t   want;
  bit                    poll_accepted = 1'b0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    err_count = 0;
  int                    polls_queued = 0;
  logic [bdlp_pkg::TICK_W-1:0] tick_clock = '0;

  poll_t directed_polls [20] = '{
    '{1'b1, 32'd100}, '{1'b0, 32'd102}, '{1'b0, 32'd103}, '{1'b0, 32'd104},
    '{1'b1, 32'd200}, '{1'b1, 32'd203}, '{1'b1, 32'd204}, '{1'b1, 32'd209},
    '{1'b1, 32'd210}, '{1'b1, 32'd213}, '{1'b0, 32'd214}, '{1'b1, 32'd215},
    '{1'b0, 32'd216}, '{1'b0, 32'd220}, '{1'b1, 32'hFFFF_FFFE}, '{1'b1, 32'd2},
    '{1'b0, 32'd3}, '{1'b1, 32'd4}, '{1'b0, 32'd5}, '{1'b0, 32'd9}
  };

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit over_limit(input logic [bdlp_pkg::TICK_W-1:0] now,
                                    input logic [bdlp_pkg::TICK_W-1:0] lim);
    logic [bdlp_pkg::TICK_W-1:0] d;
    d = now - stamp;
    return d > lim;
  endfunction

  task automatic track_button(input poll_t p);
    logic                act;
    bdlp_pkg::event_t    ev;
    bdlp_pkg::step_res_t r;
    act = (p.raw_level == cur_active);
    ev = bdlp_pkg::EV_NONE;
    case (btn_state)
      bdlp_pkg::CODE_IDLE: begin
        if (act) begin
          stamp = p.tick_now;
          btn_state = bdlp_pkg::CODE_DEB_ON;
        end
      end
      bdlp_pkg::CODE_DEB_ON: begin
        if (act == prev_act) begin
          if (over_limit(p.tick_now, cur_press_deb)) begin
            if (act) begin
              btn_state = bdlp_pkg::CODE_SHORT;
              stamp = p.tick_now;
              case (cur_mode)
                bdlp_pkg::MODE_MOMENTARY: ev = bdlp_pkg::EV_SHORT;
                bdlp_pkg::MODE_LATCH: begin
                  if (sw_on) begin
                    ev = bdlp_pkg::EV_SW_OFF;
                    sw_on = 1'b0;
                  end else begin
                    ev = bdlp_pkg::EV_SHORT;
                  end
                end
                bdlp_pkg::MODE_TOGGLE: begin
                  ev = sw_on ? bdlp_pkg::EV_SW_OFF : bdlp_pkg::EV_SW_ON;
                  sw_on = ~sw_on;
                end
                default: ;
              endcase
            end else begin
              btn_state = bdlp_pkg::CODE_IDLE;
            end
          end
        end else if (act) begin
          stamp = p.tick_now;
        end
      end
      bdlp_pkg::CODE_SHORT: begin
        if (!act) begin
          btn_state = bdlp_pkg::CODE_SHORT_OFF;
          stamp = p.tick_now;
        end else if (cur_long != 0 && over_limit(p.tick_now, cur_long)) begin
          btn_state = bdlp_pkg::CODE_LONG;
          stamp = p.tick_now;
          if (cur_mode == bdlp_pkg::MODE_MOMENTARY) begin
            ev = bdlp_pkg::EV_LONG;
          end else if (cur_mode == bdlp_pkg::MODE_LATCH) begin
            sw_on = 1'b1;
            ev = bdlp_pkg::EV_SW_ON;
          end
        end
      end
      bdlp_pkg::CODE_LONG: begin
        if (!act) begin
          btn_state = bdlp_pkg::CODE_LONG_OFF;
          stamp = p.tick_now;
        end else if (cur_repeat != 0 && over_limit(p.tick_now, cur_repeat)) begin
          stamp = p.tick_now;
          ev = bdlp_pkg::EV_REPEAT;
        end
      end
      bdlp_pkg::CODE_SHORT_OFF, bdlp_pkg::CODE_LONG_OFF: begin
        if (act) begin
          stamp = p.tick_now;
          btn_state = (btn_state == bdlp_pkg::CODE_SHORT_OFF) ? bdlp_pkg::CODE_SHORT
                                                              : bdlp_pkg::CODE_LONG;
        end else if (act != prev_act) begin
          stamp = p.tick_now;
        end else if (over_limit(p.tick_now, cur_release_deb)) begin
          ev = (btn_state == bdlp_pkg::CODE_SHORT_OFF) ? bdlp_pkg::EV_SHORT_REL
                                                       : bdlp_pkg::EV_LONG_REL;
          btn_state = bdlp_pkg::CODE_IDLE;
          stamp = p.tick_now;
        end
      end
      default: begin
        btn_state = bdlp_pkg::CODE_IDLE;
        stamp = p.tick_now;
      end
    endcase
    prev_act = act;
    r.event_code = ev;
    r.button_state = btn_state;
    if (cur_mode == bdlp_pkg::MODE_MOMENTARY)
      r.logic_value = (btn_state >= bdlp_pkg::CODE_SHORT &&
                       btn_state <= bdlp_pkg::CODE_LONG_OFF);
    else
      r.logic_value = sw_on;
    expected_reports.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, exp_val);
    err_count++;
  endtask

  task automatic write_reg(input logic [bdlp_pkg::IDX_W-1:0] idx,
                           input logic [bdlp_pkg::TICK_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      bdlp_pkg::REG_ACTIVE_LEVEL: cur_active = val[0];
      bdlp_pkg::REG_PRESS_DEB:    cur_press_deb = val;
      bdlp_pkg::REG_RELEASE_DEB:  cur_release_deb = val;
      bdlp_pkg::REG_LONG_PRESS:   cur_long = val;
      bdlp_pkg::REG_REPEAT:       cur_repeat = val;
      bdlp_pkg::REG_BUTTON_MODE:  cur_mode = val[1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic act, input logic [bdlp_pkg::TICK_W-1:0] pdeb,
                               input logic [bdlp_pkg::TICK_W-1:0] rdeb,
                               input logic [bdlp_pkg::TICK_W-1:0] lng,
                               input logic [bdlp_pkg::TICK_W-1:0] rep,
                               input logic [1:0] mode);
    write_reg(bdlp_pkg::REG_ACTIVE_LEVEL, {31'd0, act});
    write_reg(bdlp_pkg::REG_PRESS_DEB, pdeb);
    write_reg(bdlp_pkg::REG_RELEASE_DEB, rdeb);
    write_reg(bdlp_pkg::REG_LONG_PRESS, lng);
    write_reg(bdlp_pkg::REG_REPEAT, rep);
    write_reg(bdlp_pkg::REG_BUTTON_MODE, {30'd0, mode});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampled at the rising edge, where the queues and valid cannot race with the driver
  task automatic wait_drained();
    @(posedge clk);
    while (!(poll_queue.size() == 0 && !poll_if.valid && expected_reports.size() == 0))
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_run(input int n, input logic lvl, input bit bounce);
    poll_t p;
    repeat (n) begin
      tick_clock += $urandom_range(1, 4);
      p.raw_level = bounce ? 1'($urandom_range(0, 1)) : lvl;
      p.tick_now = tick_clock;
      poll_queue.push_back(p);
      polls_queued++;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      poll_if.valid <= 1'b0;
    end else if (!poll_if.valid || poll_accepted) begin
      if (poll_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        outgoing_poll = poll_queue.pop_front();
        poll_if.valid <= 1'b1;
        poll_if.raw_level <= outgoing_poll.raw_level;
        poll_if.tick_now <= outgoing_poll.tick_now;
      end else begin
        poll_if.valid <= 1'b0;
      end
    end
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    poll_accepted = !rst && poll_if.valid && poll_if.ready;
    if (poll_accepted)
      track_button('{poll_if.raw_level, poll_if.tick_now});
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result beat with nothing expected", res_if.event_code, 0);
      end else begin
        want = expected_reports.pop_front();
        if (res_if.event_code !== want.event_code)
          report_mismatch("event_code", res_if.event_code, want.event_code);
        if (res_if.button_state !== want.button_state)
          report_mismatch("button_state", res_if.button_state, want.button_state);
        if (res_if.logic_value !== want.logic_value)
          report_mismatch("logic_value", res_if.logic_value, want.logic_value);
      end
    end
  end

  initial begin
    poll_if.valid = 1'b0;
    poll_if.raw_level = 1'b0;
    poll_if.tick_now = '0;
    res_if.ready = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 12;
    recv_idle_pct = 73;
    apply_setting(1'b1, 32'd3, 32'd3, 32'd5, 32'd2, bdlp_pkg::MODE_MOMENTARY);
    foreach (directed_polls[i])
      poll_queue.push_back(directed_polls[i]);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 12;
        recv_idle_pct = 73;
      end else if (ph < 8) begin
        send_idle_pct = 73;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 0)
        apply_setting(1'b0, '0, '0, '0, '0, bdlp_pkg::MODE_LATCH);
      else if (ph == 1)
        apply_setting(1'b1, '1, '1, '1, '1, bdlp_pkg::MODE_TOGGLE);
      else
        apply_setting(1'($urandom_range(0, 1)), $urandom_range(0, 12), $urandom_range(0, 12),
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40),
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10),
                      2'((ph + 1) % 4));
      // some phases start just short of the tick wrap
      tick_clock = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFC0 : $urandom();
      polls_queued = 0;
      while (polls_queued < PHASE_POLLS) begin
        if ($urandom_range(0, 99) < 15) begin
          if ($urandom_range(0, 1))
            tick_clock = $urandom();
          push_run(1, 1'b0, 1'b1);
        end else begin
          // bounce, hold, bounce, release
          push_run($urandom_range(0, 3), cur_active, 1'b1);
          push_run($urandom_range(1, 40), cur_active, 1'b0);
          push_run($urandom_range(0, 3), ~cur_active, 1'b1);
          push_run($urandom_range(1, 12), ~cur_active, 1'b0);
        end
      end
      wait_drained();
    end

    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
